// ===== rtl/hla_pkg.sv =====
// hla_pkg: shared types, codes and trig table helpers for the hough line accumulator
// no dependencies; used by hla_cell and hough_line_accumulator_core
package hla_pkg;

   localparam int COUNT_W    = 18;
   localparam int ADDR_MAX_W = 12;
   localparam int OFFSET_W   = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;

   // item actions
   localparam logic [1:0] ACT_VOTE  = 2'd0;
   localparam logic [1:0] ACT_SCAN  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // register indexes
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_OFFSET    = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VOTE,
      ST_SCAN_RD,
      ST_SCAN_LD,
      ST_SCAN_WALK,
      ST_SCAN_END,
      ST_CLEAR
   } state_type;

   // vote token passed down the chain
   typedef struct packed {
      logic       valid;
      logic [8:0] x;
      logic [8:0] y;
   } vote_tok_type;

   // one cell's scan report, shifted toward cell 0
   typedef struct packed {
      logic               hit;
      logic [COUNT_W-1:0] count;
   } scan_ent_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                  clr_we;
      logic                  scan_rd;
      logic                  scan_load;
      logic                  scan_shift;
      logic [ADDR_MAX_W-1:0] addr;
      logic [COUNT_W-1:0]    threshold;
      logic [OFFSET_W-1:0]   rho_offset;
   } cell_ctl_type;

   // clamp at zero and round half up from q30 to q14
   function automatic int to_q14(input longint v);
      longint c;
      c = (v < 0) ? 64'sd0 : v;
      return int'((c + 64'sd32768) >>> 16);
   endfunction

   // taylor sine of a q30 angle in [0, pi/2], q14 result
   function automatic int trig_sin(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint s;
      x2 = (x * x) >> 30;
      t = x;
      s = longint'(t);
      t = ((t * x2) >> 30) / 6;   s = s - longint'(t);
      t = ((t * x2) >> 30) / 20;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 42;  s = s - longint'(t);
      t = ((t * x2) >> 30) / 72;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 110; s = s - longint'(t);
      t = ((t * x2) >> 30) / 156; s = s + longint'(t);
      t = ((t * x2) >> 30) / 210; s = s - longint'(t);
      return to_q14(s);
   endfunction

   // taylor cosine of a q30 angle in [0, pi/2], q14 result
   function automatic int trig_cos(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint c;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      c = longint'(t);
      t = ((t * x2) >> 30) / 2;   c = c - longint'(t);
      t = ((t * x2) >> 30) / 12;  c = c + longint'(t);
      t = ((t * x2) >> 30) / 30;  c = c - longint'(t);
      t = ((t * x2) >> 30) / 56;  c = c + longint'(t);
      t = ((t * x2) >> 30) / 90;  c = c - longint'(t);
      t = ((t * x2) >> 30) / 132; c = c + longint'(t);
      t = ((t * x2) >> 30) / 182; c = c - longint'(t);
      return to_q14(c);
   endfunction

endpackage

// ===== rtl/hough_line_accumulator_core.sv =====
// hough_line_accumulator_core: top level, item sequencer and the row of theta cells
// depends on hla_pkg and hla_cell
//
// A vote item runs down a chain of THETA_BINS cells, one theta bin each, and keeps the
// block busy while it passes: each cell multiplies, then does a read-modify-write of its
// own column memory. A scan item does one parallel read of the row, then the reports
// shift out of cell 0 one bin per cycle; results appear as one-cycle
// rsp_valid strobes that the receiver must take as they come. A clear item writes
// one row per cycle in every cell at once; the same pass runs after
// reset and holds busy high until every row is cleared.
module hough_line_accumulator_core
   import hla_pkg::*;
#(
   parameter int THETA_BINS = 64,
   parameter int RHO_ROWS   = 2048,
   parameter int MAX_SIDE   = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_action,
   input  logic [7:0]   req_pixel_value,
   input  logic [8:0]   req_x_coord,
   input  logic [8:0]   req_y_coord,
   input  logic [10:0]  req_scan_row,
   output logic         rsp_valid,
   output logic         rsp_hit,
   output logic [10:0]  rsp_rho_index,
   output logic [5:0]   rsp_theta_index,
   output logic [17:0]  rsp_vote_count,
   output logic         rsp_last,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [17:0]  csr_wdata
);

   localparam int CW = $clog2(RHO_ROWS + THETA_BINS + 4) + 1;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [COUNT_W-1:0]  threshold_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [10:0]         row_ff;
   logic                row_ok_ff;
   logic                pend_valid_ff, pend_valid_in;
   logic [5:0]          pend_theta_ff, pend_theta_in;
   logic [COUNT_W-1:0]  pend_count_ff, pend_count_in;

   logic                out_valid_ff, out_hit_ff, out_last_ff;
   logic [5:0]          out_theta_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                emit, emit_hit, emit_last;
   logic [5:0]          emit_theta;
   logic [COUNT_W-1:0]  emit_count;

   logic                accept;
   logic                count_end;
   cell_ctl_type        ctl;
   vote_tok_type        tok [THETA_BINS+1];
   scan_ent_type        scan [THETA_BINS+1];

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign count_end = (state_ff == ST_CLEAR) ? (count_ff == CW'(RHO_ROWS - 1))
                    : (state_ff == ST_VOTE)  ? (count_ff == CW'(THETA_BINS + 1))
                    : (count_ff == CW'(THETA_BINS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_VOTE:  state_in = ST_VOTE;
                  ACT_SCAN:  state_in = ST_SCAN_RD;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_VOTE:      if (count_end) state_in = ST_IDLE;
         ST_SCAN_RD:   state_in = ST_SCAN_LD;
         ST_SCAN_LD:   state_in = ST_SCAN_WALK;
         ST_SCAN_WALK: if (count_end) state_in = ST_SCAN_END;
         ST_SCAN_END:  state_in = ST_IDLE;
         ST_CLEAR:     if (count_end) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      count_in       = '0;
      pend_valid_in  = pend_valid_ff;
      pend_theta_in  = pend_theta_ff;
      pend_count_in  = pend_count_ff;
      emit           = 1'b0;
      emit_hit       = 1'b1;
      emit_last      = 1'b0;
      emit_theta     = pend_theta_ff;
      emit_count     = pend_count_ff;
      ctl            = '0;
      ctl.threshold  = threshold_ff;
      ctl.rho_offset = offset_ff;
      ctl.addr       = ADDR_MAX_W'(row_ff);
      tok[0].valid   = accept && (req_action == ACT_VOTE) && (req_pixel_value != 8'd0)
                       && ({2'b0, req_x_coord} < 11'(MAX_SIDE))
                       && ({2'b0, req_y_coord} < 11'(MAX_SIDE));
      tok[0].x       = req_x_coord;
      tok[0].y       = req_y_coord;
      case (state_ff)
         ST_IDLE: begin
            pend_valid_in = 1'b0;
         end
         ST_VOTE: begin
            count_in = count_ff + 1'b1;
         end
         ST_SCAN_RD: begin
            ctl.scan_rd = 1'b1;
         end
         ST_SCAN_LD: begin
            ctl.scan_load = 1'b1;
         end
         ST_SCAN_WALK: begin
            ctl.scan_shift = 1'b1;
            count_in       = count_ff + 1'b1;
            if (scan[0].hit && row_ok_ff) begin
               emit          = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_theta_in = 6'(count_ff);
               pend_count_in = scan[0].count;
            end
         end
         ST_SCAN_END: begin
            emit      = 1'b1;
            emit_last = 1'b1;
            if (!pend_valid_ff) begin
               emit_hit   = 1'b0;
               emit_theta = '0;
               emit_count = '0;
            end
         end
         ST_CLEAR: begin
            ctl.clr_we = 1'b1;
            ctl.addr   = ADDR_MAX_W'(count_ff);
            count_in   = count_ff + 1'b1;
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      pend_theta_ff <= pend_theta_in;
      pend_count_ff <= pend_count_in;
      out_hit_ff    <= emit_hit;
      out_last_ff   <= emit_last;
      out_theta_ff  <= emit_theta;
      out_count_ff  <= emit_count;
      if (accept) begin
         row_ff    <= req_scan_row;
         row_ok_ff <= {2'b0, req_scan_row} < 13'(RHO_ROWS);
      end
      if (reset) begin
         state_ff      <= ST_CLEAR;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         threshold_ff  <= '0;
         offset_ff     <= 10'd724;
      end else begin
         state_ff      <= state_in;
         count_ff      <= (state_in == state_ff) ? count_in : '0;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= emit;
         if (csr_we && csr_index == REG_THRESHOLD) begin
            threshold_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_OFFSET) begin
            offset_ff <= csr_wdata[OFFSET_W-1:0];
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_rho_index   = row_ff;
   assign rsp_theta_index = out_theta_ff;
   assign rsp_vote_count  = out_count_ff;
   assign rsp_last        = out_last_ff;

   // chain of theta cells
   assign scan[THETA_BINS] = '0;
   for (genvar k = 0; k < THETA_BINS; k++) begin : g_cell
      hla_cell #(
         .K    (k),
         .BINS (THETA_BINS),
         .ROWS (RHO_ROWS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .tok_in   (tok[k]),
         .tok_out  (tok[k+1]),
         .scan_in  (scan[k+1]),
         .scan_out (scan[k])
      );
   end

endmodule

// ===== rtl/hla_cell.sv =====
// hla_cell: one theta bin of the accumulator, holding that bin's column of counts
// depends on hla_pkg
module hla_cell
   import hla_pkg::*;
#(
   parameter int K    = 0,
   parameter int BINS = 64,
   parameter int ROWS = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  vote_tok_type tok_in,
   output vote_tok_type tok_out,
   input  scan_ent_type scan_in,
   output scan_ent_type scan_out
);

   localparam int RW = $clog2(ROWS);
   localparam int KF = (2 * K > BINS) ? BINS - K : K;
   localparam bit NEG_COS = (2 * K > BINS);
   localparam longint unsigned ANG = (64'(KF) * PI_Q30) / 64'(BINS);
   localparam int SIN_I = trig_sin(ANG);
   localparam int COS_I = NEG_COS ? -trig_cos(ANG) : trig_cos(ANG);
   localparam logic signed [15:0] SIN_Q14 = 16'(SIN_I);
   localparam logic signed [15:0] COS_Q14 = 16'(COS_I);

   logic [COUNT_W-1:0] mem [ROWS];

   vote_tok_type        tok_ff;
   logic                prod_valid_ff;
   logic signed [25:0]  prod_x_ff;
   logic signed [25:0]  prod_y_ff;
   logic                wr_pend_ff;
   logic [RW-1:0]       wr_addr_ff;
   logic [COUNT_W-1:0]  rdata_ff;
   scan_ent_type        scan_ff;

   logic signed [26:0]  sum;
   logic signed [12:0]  quo;
   logic signed [13:0]  row;
   logic                row_ok;
   logic [RW-1:0]       rd_addr;
   logic                we;
   logic [RW-1:0]       waddr;
   logic [COUNT_W-1:0]  wdata;
   scan_ent_type        scan_in_mux;

   assign tok_out  = tok_ff;
   assign scan_out = scan_ff;

   // rho from the registered products, truncated toward zero
   always_comb begin
      sum    = 27'(prod_x_ff) + 27'(prod_y_ff);
      quo    = 13'((sum + ((sum < 0) ? 27'sd16383 : 27'sd0)) >>> 14);
      row    = 14'(quo) + $signed({4'b0, ctl.rho_offset});
      row_ok = prod_valid_ff && (row >= 0) && (row < 14'(ROWS));
   end

   // memory port selection
   always_comb begin
      rd_addr = ctl.scan_rd ? ctl.addr[RW-1:0] : row[RW-1:0];
      we      = ctl.clr_we || wr_pend_ff;
      waddr   = ctl.clr_we ? ctl.addr[RW-1:0] : wr_addr_ff;
      wdata   = ctl.clr_we ? '0
                : ((rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + 1'b1);
   end

   // scan shift register input
   always_comb begin
      scan_in_mux = scan_ff;
      if (ctl.scan_load) begin
         scan_in_mux.hit   = rdata_ff > ctl.threshold;
         scan_in_mux.count = rdata_ff;
      end else if (ctl.scan_shift) begin
         scan_in_mux = scan_in;
      end
   end

   // count storage
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   // vote pipeline and scan register
   always_ff @(posedge clock) begin
      prod_x_ff  <= $signed({1'b0, tok_in.x}) * COS_Q14;
      prod_y_ff  <= $signed({1'b0, tok_in.y}) * SIN_Q14;
      tok_ff.x   <= tok_in.x;
      tok_ff.y   <= tok_in.y;
      wr_addr_ff <= row[RW-1:0];
      scan_ff    <= scan_in_mux;
      if (reset) begin
         tok_ff.valid  <= 1'b0;
         prod_valid_ff <= 1'b0;
         wr_pend_ff    <= 1'b0;
      end else begin
         tok_ff.valid  <= tok_in.valid;
         prod_valid_ff <= tok_in.valid;
         wr_pend_ff    <= row_ok && !ctl.scan_rd;
      end
   end

endmodule
